// ----- sv/awnn_pkg.sv -----
// shared types and constants for the affine warp nearest-neighbor block
// no dependencies; imported by affine_warp_nearest_neighbor
package awnn_pkg;

  // frame store geometry and coefficient format
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 16;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths fixed by the interface
  localparam int PIX_POS_W  = 9;
  localparam int CHAN_W     = 8;
  localparam int PIXEL_W    = 3 * CHAN_W;
  localparam int CFG_SIZE_W = 10;
  localparam int COEF_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // signed coef times zero-extended position, then a sum of two products and an offset
  localparam int PROD_W  = COEF_W + PIX_POS_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int FLOOR_W = SUM_W - FRAC_BITS;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_IMAGE_WIDTH  = 3'd0,
    IDX_IMAGE_HEIGHT = 3'd1,
    IDX_COEF_A       = 3'd2,
    IDX_COEF_B       = 3'd3,
    IDX_OFFSET_P     = 3'd4,
    IDX_COEF_C       = 3'd5,
    IDX_COEF_D       = 3'd6,
    IDX_OFFSET_Q     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic                 kind;
    logic [PIX_POS_W-1:0] pixel_row;
    logic [PIX_POS_W-1:0] pixel_col;
    logic [CHAN_W-1:0]    load_chan0;
    logic [CHAN_W-1:0]    load_chan1;
    logic [CHAN_W-1:0]    load_chan2;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_chan0;
    logic [CHAN_W-1:0] out_chan1;
    logic [CHAN_W-1:0] out_chan2;
    logic              inside_res;
  } out_item_t;

endpackage

// ----- sv/affine_warp_nearest_neighbor.sv -----
// affine warp with nearest-neighbor sampling by inverse mapping
// a request's result shows once it has passed the pipeline stages and the output register
// throughput: one item per cycle; the pipeline stalls as a whole only while
//   the output register holds an item that is not taken
// reset (rst_n low, synchronous): pipeline emptied, registers to identity warp
//   over 512x512; the frame store is not cleared and reads as garbage until loaded
module affine_warp_nearest_neighbor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  awnn_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output awnn_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [awnn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [awnn_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import awnn_pkg::*;

  // pipeline:
  //   stage 1: four coefficient products (one multiplier each)
  //   stage 2: x and y sums with offsets
  //   stage 3: truncation toward zero, bounds check, store address
  //   stage 4: frame store access (loads write here, requests read here,
  //            so loads and requests hit the store in arrival order)
  //   output : zero the pixel when the point falls outside

  localparam logic [PIX_POS_W:0] ROW_LIM = (PIX_POS_W+1)'(MAX_HEIGHT);
  localparam logic [PIX_POS_W:0] COL_LIM = (PIX_POS_W+1)'(MAX_WIDTH);
  localparam int X_W = $clog2(MAX_WIDTH);
  localparam int Y_W = $clog2(MAX_HEIGHT);

  // configuration registers
  logic [CFG_SIZE_W-1:0]    img_w_r, img_h_r;
  logic signed [COEF_W-1:0] coef_a_r, coef_b_r, off_p_r, coef_c_r, coef_d_r, off_q_r;
  logic [CFG_SIZE_W-1:0]    cfg_size;

  // whole pipeline moves when the output register is free or being emptied
  logic adv;

  // stage 1
  logic                     s1_valid_r;
  logic                     s1_kind_r;
  logic                     s1_ld_ok_r;
  logic [PIX_POS_W-1:0]     s1_row_r, s1_col_r;
  logic [PIXEL_W-1:0]       s1_pix_r;
  logic signed [PROD_W-1:0] s1_ax_r, s1_bx_r, s1_cy_r, s1_dy_r;
  logic signed [PIX_POS_W:0] in_col_s, in_row_s;

  // stage 2
  logic                    s2_valid_r;
  logic                    s2_kind_r;
  logic                    s2_ld_ok_r;
  logic [PIX_POS_W-1:0]    s2_row_r, s2_col_r;
  logic [PIXEL_W-1:0]      s2_pix_r;
  logic signed [SUM_W-1:0] s2_x_r, s2_y_r;

  // stage 3
  logic                    s3_valid_r;
  logic                    s3_kind_r;
  logic                    s3_wr_ok_r;
  logic                    s3_inside_r;
  logic [ADDR_W-1:0]       s3_addr_r;
  logic [PIXEL_W-1:0]      s3_pix_r;
  logic                    x_in, y_in;
  logic [X_W-1:0]          x_idx;
  logic [Y_W-1:0]          y_idx;
  logic [ADDR_W-1:0]       ld_addr, rq_addr;

  // stage 4
  logic                    s4_valid_r;
  logic                    s4_inside_r;
  logic [PIXEL_W-1:0]      s4_rd_r;
  logic [PIXEL_W-1:0]      frame_store [0:STORE_DEPTH-1];

  // output register
  logic                    out_valid_r;
  out_item_t               out_data_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // image sizes above the store are taken as the store size
  assign cfg_size = cfg_wdata[CFG_SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= CFG_SIZE_W'(MAX_WIDTH);
      img_h_r  <= CFG_SIZE_W'(MAX_HEIGHT);
      coef_a_r <= COEF_W'(1 << FRAC_BITS);
      coef_b_r <= '0;
      off_p_r  <= '0;
      coef_c_r <= '0;
      coef_d_r <= COEF_W'(1 << FRAC_BITS);
      off_q_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        IDX_IMAGE_WIDTH:  img_w_r <= (int'(cfg_size) > MAX_WIDTH)  ?
                                     CFG_SIZE_W'(MAX_WIDTH)  : cfg_size;
        IDX_IMAGE_HEIGHT: img_h_r <= (int'(cfg_size) > MAX_HEIGHT) ?
                                     CFG_SIZE_W'(MAX_HEIGHT) : cfg_size;
        IDX_COEF_A:       coef_a_r <= cfg_wdata[COEF_W-1:0];
        IDX_COEF_B:       coef_b_r <= cfg_wdata[COEF_W-1:0];
        IDX_OFFSET_P:     off_p_r  <= cfg_wdata[COEF_W-1:0];
        IDX_COEF_C:       coef_c_r <= cfg_wdata[COEF_W-1:0];
        IDX_COEF_D:       coef_d_r <= cfg_wdata[COEF_W-1:0];
        IDX_OFFSET_Q:     off_q_r  <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      // loads retire at the store and send nothing on
      s4_valid_r  <= s3_valid_r && (s3_kind_r == KIND_REQ);
      out_valid_r <= s4_valid_r;
    end
  end

  // stage 1: products of coefficients with destination position
  assign in_col_s = signed'({1'b0, in_data.pixel_col});
  assign in_row_s = signed'({1'b0, in_data.pixel_row});

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r  <= in_data.kind;
      s1_ld_ok_r <= ({1'b0, in_data.pixel_row} < ROW_LIM) &&
                    ({1'b0, in_data.pixel_col} < COL_LIM);
      s1_row_r   <= in_data.pixel_row;
      s1_col_r   <= in_data.pixel_col;
      s1_pix_r   <= {in_data.load_chan2, in_data.load_chan1, in_data.load_chan0};
      s1_ax_r    <= PROD_W'(coef_a_r * in_col_s);
      s1_bx_r    <= PROD_W'(coef_b_r * in_row_s);
      s1_cy_r    <= PROD_W'(coef_c_r * in_col_s);
      s1_dy_r    <= PROD_W'(coef_d_r * in_row_s);
    end
  end

  // stage 2: source coordinates in fixed point
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind_r  <= s1_kind_r;
      s2_ld_ok_r <= s1_ld_ok_r;
      s2_row_r   <= s1_row_r;
      s2_col_r   <= s1_col_r;
      s2_pix_r   <= s1_pix_r;
      s2_x_r     <= SUM_W'(s1_ax_r) + SUM_W'(s1_bx_r) + SUM_W'(off_p_r);
      s2_y_r     <= SUM_W'(s1_cy_r) + SUM_W'(s1_dy_r) + SUM_W'(off_q_r);
    end
  end

  // stage 3: truncation toward zero and bounds
  // a negative value lands inside only when it lies in (-1, 0): floor is -1
  // with a nonzero fraction, and it truncates to index zero
  function automatic logic axis_inside(input logic signed [SUM_W-1:0] v,
                                       input logic [CFG_SIZE_W-1:0]   lim);
    logic [FLOOR_W-1:0] fl;
    logic               neg;
    logic               near_zero;
    fl        = v[SUM_W-1:FRAC_BITS];
    neg       = v[SUM_W-1];
    near_zero = neg && (fl == '1) && (|v[FRAC_BITS-1:0]);
    return (!neg && (fl < {{(FLOOR_W-CFG_SIZE_W){1'b0}}, lim})) ||
           (near_zero && (lim != '0));
  endfunction

  assign x_in  = axis_inside(s2_x_r, img_w_r);
  assign y_in  = axis_inside(s2_y_r, img_h_r);
  assign x_idx = s2_x_r[SUM_W-1] ? '0 : s2_x_r[FRAC_BITS +: X_W];
  assign y_idx = s2_y_r[SUM_W-1] ? '0 : s2_y_r[FRAC_BITS +: Y_W];

  assign ld_addr = ADDR_W'(ADDR_W'(s2_row_r) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(s2_col_r);
  assign rq_addr = ADDR_W'(ADDR_W'(y_idx) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(x_idx);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kind_r   <= s2_kind_r;
      s3_wr_ok_r  <= s2_ld_ok_r;
      s3_inside_r <= x_in && y_in;
      s3_addr_r   <= (s2_kind_r == KIND_LOAD) ? ld_addr : rq_addr;
      s3_pix_r    <= s2_pix_r;
    end
  end

  // stage 4: frame store, one access per cycle while the pipeline advances
  always_ff @(posedge clk) begin
    if (adv && s3_valid_r) begin
      if (s3_kind_r == KIND_LOAD) begin
        if (s3_wr_ok_r) begin
          frame_store[s3_addr_r] <= s3_pix_r;
        end
      end else begin
        s4_rd_r <= frame_store[s3_addr_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_inside_r <= s3_inside_r;
    end
  end

  // output register: outside points give a black pixel
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.out_chan0  <= s4_inside_r ? s4_rd_r[0*CHAN_W +: CHAN_W] : '0;
      out_data_r.out_chan1  <= s4_inside_r ? s4_rd_r[1*CHAN_W +: CHAN_W] : '0;
      out_data_r.out_chan2  <= s4_inside_r ? s4_rd_r[2*CHAN_W +: CHAN_W] : '0;
      out_data_r.inside_res <= s4_inside_r;
    end
  end

  // a request leaving the store stage becomes a result on the next edge
  a_req_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s4_valid_r) |=> out_valid_r)
    else $error("request at store stage did not reach output");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s3_valid_r && (s3_kind_r == KIND_LOAD)) |=> !s4_valid_r)
    else $error("load item passed the store stage");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output free");

  // outside points carry zero channels
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.inside_res) |->
      (out_data.out_chan0 == '0 && out_data.out_chan1 == '0 && out_data.out_chan2 == '0))
    else $error("outside result with nonzero pixel");

endmodule

// ----- dv/affine_warp_nearest_neighbor_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the affine warp nearest-neighbor block: loads source pixels,
// requests destination pixels, and compares each result with a predicted source fetch
// depends on awnn_pkg and affine_warp_nearest_neighbor
module affine_warp_nearest_neighbor_test;
  import awnn_pkg::*;

  // cycles to let pass after the last result before touching registers or ending;
  // a request is answered once it has passed the pipeline, loads give no result
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_MISMATCH_LINES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = IDX_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  affine_warp_nearest_neighbor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // our own copy of the source frame; src_loaded marks entries ever written,
  // so that no request is ever mapped onto an undefined entry
  logic [PIXEL_W-1:0] src_frame [STORE_DEPTH];
  bit src_loaded [STORE_DEPTH];

  // warp registers as the block should hold them (reset: identity over 512x512)
  int unsigned cols_in_use = MAX_WIDTH;
  int unsigned rows_in_use = MAX_HEIGHT;
  longint warp_a = longint'(1) << FRAC_BITS;
  longint warp_b = 0;
  longint warp_p = 0;
  longint warp_c = 0;
  longint warp_d = longint'(1) << FRAC_BITS;
  longint warp_q = 0;

  out_item_t expected_pixels [$];
  out_item_t oldest_pixel;
  int unsigned failures = 0;
  int unsigned mismatch_lines = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // inverse mapping of destination (row, col) to a source entry;
  // division truncates toward zero, which is the rounding the block uses
  function automatic bit locate_source(input logic [PIX_POS_W-1:0] row,
                                       input logic [PIX_POS_W-1:0] col,
                                       output int unsigned addr);
    longint one;
    longint sx;
    longint sy;
    one = longint'(1) << FRAC_BITS;
    sx = (warp_a * longint'(col) + warp_b * longint'(row) + warp_p) / one;
    sy = (warp_c * longint'(col) + warp_d * longint'(row) + warp_q) / one;
    addr = 0;
    if (sx < 0 || sy < 0 || sx >= longint'(cols_in_use) || sy >= longint'(rows_in_use))
      return 1'b0;
    addr = int'(sy) * MAX_WIDTH + int'(sx);
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_fixed(input int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      failures++;
      if (mismatch_lines < MAX_MISMATCH_LINES) begin
        mismatch_lines++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endfunction

  // result side: random stall, every taken item checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        failures++;
        if (mismatch_lines < MAX_MISMATCH_LINES) begin
          mismatch_lines++;
          $display("%0t: result with nothing pending, expected none, actual %h",
                   $time, out_data);
        end
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        check_field("out_chan0", oldest_pixel.out_chan0, out_data.out_chan0);
        check_field("out_chan1", oldest_pixel.out_chan1, out_data.out_chan1);
        check_field("out_chan2", oldest_pixel.out_chan2, out_data.out_chan2);
        check_field("inside_res", 8'(oldest_pixel.inside_res), 8'(out_data.inside_res));
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // one item over the input channel; the prediction is taken at the edge that accepts it
  task automatic send_item(input in_item_t item);
    int unsigned addr;
    out_item_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (item.kind == KIND_LOAD) begin
      addr = int'(item.pixel_row) * MAX_WIDTH + int'(item.pixel_col);
      src_frame[addr] = {item.load_chan2, item.load_chan1, item.load_chan0};
      src_loaded[addr] = 1'b1;
    end else begin
      want = '0;
      want.inside_res = locate_source(item.pixel_row, item.pixel_col, addr);
      if (want.inside_res) begin
        want.out_chan0 = src_frame[addr][7:0];
        want.out_chan1 = src_frame[addr][15:8];
        want.out_chan2 = src_frame[addr][23:16];
      end
      expected_pixels.push_back(want);
    end
  endtask

  task automatic send_load(input int unsigned row, input int unsigned col,
                           input logic [PIXEL_W-1:0] pix);
    in_item_t item;
    item.kind = KIND_LOAD;
    item.pixel_row = PIX_POS_W'(row);
    item.pixel_col = PIX_POS_W'(col);
    item.load_chan0 = pix[7:0];
    item.load_chan1 = pix[15:8];
    item.load_chan2 = pix[23:16];
    send_item(item);
  endtask

  // a request that lands on a never-loaded entry gets that entry loaded first
  task automatic send_request(input int unsigned row, input int unsigned col);
    in_item_t item;
    int unsigned addr;
    if (locate_source(PIX_POS_W'(row), PIX_POS_W'(col), addr) && !src_loaded[addr])
      send_load(addr / MAX_WIDTH, addr % MAX_WIDTH, PIXEL_W'($urandom));
    item = '0;
    item.kind = KIND_REQ;
    item.pixel_row = PIX_POS_W'(row);
    item.pixel_col = PIX_POS_W'(col);
    item.load_chan0 = 8'($urandom);
    item.load_chan1 = 8'($urandom);
    item.load_chan2 = 8'($urandom);
    send_item(item);
  endtask

  // sender goes quiet until every pending result is back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  // fully idle: also lets trailing loads leave the pipeline
  task automatic settle_block();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      IDX_IMAGE_WIDTH:  cols_in_use = (val[9:0] > MAX_WIDTH) ? MAX_WIDTH : val[9:0];
      IDX_IMAGE_HEIGHT: rows_in_use = (val[9:0] > MAX_HEIGHT) ? MAX_HEIGHT : val[9:0];
      IDX_COEF_A:       warp_a = longint'($signed(val));
      IDX_COEF_B:       warp_b = longint'($signed(val));
      IDX_OFFSET_P:     warp_p = longint'($signed(val));
      IDX_COEF_C:       warp_c = longint'($signed(val));
      IDX_COEF_D:       warp_d = longint'($signed(val));
      IDX_OFFSET_Q:     warp_q = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  // identity warp at reset: corners of the store with extreme channel values
  task automatic test_store_corners();
    send_load(0, 0, 24'h000000);
    send_load(511, 511, 24'hFFFFFF);
    send_load(0, 511, 24'hC35AA5);
    send_load(511, 0, 24'h5AC33C);
    send_request(0, 0);
    send_request(511, 511);
    send_request(0, 511);
    send_request(511, 0);
  endtask

  // request right behind a load of the same entry, then an overwrite
  task automatic test_load_then_read();
    send_load(3, 7, PIXEL_W'($urandom));
    send_request(3, 7);
    send_load(3, 7, PIXEL_W'($urandom));
    send_request(3, 7);
  endtask

  // zero width, width above the store size, a height with junk above bit 9
  task automatic test_size_registers();
    settle_block();
    write_reg(IDX_IMAGE_WIDTH, 32'h0000_0000);
    send_request(0, 0);
    settle_block();
    write_reg(IDX_IMAGE_WIDTH, 32'h0000_03FF);
    write_reg(IDX_IMAGE_HEIGHT, 32'hFFFF_FC01);
    send_request(0, 511);
    send_request(1, 0);
  endtask

  // coordinates just below zero still truncate to zero and count as inside
  task automatic test_negative_fraction();
    settle_block();
    write_reg(IDX_IMAGE_HEIGHT, 32'd512);
    write_reg(IDX_OFFSET_P, 32'hFFFF_8000);
    write_reg(IDX_OFFSET_Q, 32'hFFFF_0001);
    send_request(0, 0);
    send_request(1, 1);
  endtask

  // full-scale coefficients and offsets; wide sums must not wrap
  task automatic test_extreme_coefficients();
    settle_block();
    write_reg(IDX_COEF_A, 32'h7FFF_FFFF);
    write_reg(IDX_COEF_B, 32'h8000_0000);
    write_reg(IDX_COEF_C, 32'h8000_0000);
    write_reg(IDX_COEF_D, 32'h7FFF_FFFF);
    write_reg(IDX_OFFSET_P, 32'h0000_0000);
    write_reg(IDX_OFFSET_Q, 32'h0000_0000);
    send_request(1, 1);
    send_request(511, 511);
    send_request(0, 511);
    settle_block();
    write_reg(IDX_OFFSET_P, 32'h8000_0000);
    send_request(0, 0);
    settle_block();
    write_reg(IDX_OFFSET_P, 32'h7FFF_FFFF);
    send_request(0, 0);
  endtask

  // destination pixels beyond the image size are still mapped and answered
  task automatic test_out_of_size_requests();
    settle_block();
    write_reg(IDX_IMAGE_WIDTH, 32'hABCD_E410);
    write_reg(IDX_IMAGE_HEIGHT, 32'd16);
    write_reg(IDX_COEF_A, 32'h0000_4000);
    write_reg(IDX_COEF_B, 32'h0000_0000);
    write_reg(IDX_OFFSET_P, 32'h0000_0000);
    write_reg(IDX_COEF_C, 32'h0000_0000);
    write_reg(IDX_COEF_D, 32'h0000_4000);
    write_reg(IDX_OFFSET_Q, 32'h0000_0000);
    send_request(60, 60);
    send_request(64, 0);
    send_request(0, 100);
  endtask

  // new warp and image size; mostly small images with transforms that land inside
  task automatic randomize_warp();
    int unsigned style;
    int unsigned w;
    int unsigned h;
    logic [31:0] ca, cb, cc, cd, op, oq;
    style = $urandom_range(0, 5);
    w = $urandom_range(1, 32);
    h = $urandom_range(1, 32);
    ca = 32'h0001_0000 + rand_fixed(8192);
    cb = rand_fixed(16384);
    cc = rand_fixed(16384);
    cd = 32'h0001_0000 + rand_fixed(8192);
    op = rand_fixed(4 << FRAC_BITS);
    oq = rand_fixed(4 << FRAC_BITS);
    case (style)
      1: begin
        ca = rand_fixed(2 << FRAC_BITS);
        cd = rand_fixed(2 << FRAC_BITS);
        cb = rand_fixed(4096);
        cc = rand_fixed(4096);
        op = rand_fixed(32 << FRAC_BITS);
        oq = rand_fixed(32 << FRAC_BITS);
      end
      2: begin
        ca = rand_fixed(98304);
        cb = rand_fixed(98304);
        cc = rand_fixed(98304);
        cd = rand_fixed(98304);
        op = rand_fixed(32 << FRAC_BITS);
        oq = rand_fixed(32 << FRAC_BITS);
      end
      3: begin
        ca = $urandom;
        cb = $urandom;
        cc = $urandom;
        cd = $urandom;
        op = $urandom;
        oq = $urandom;
      end
      4: begin
        // large frame, sometimes given above the store size
        w = $urandom_range(0, 1) ? MAX_WIDTH : $urandom_range(1, 1023);
        h = $urandom_range(0, 1) ? MAX_HEIGHT : $urandom_range(1, 1023);
        ca = rand_fixed(98304);
        cb = rand_fixed(98304);
        cc = rand_fixed(98304);
        cd = rand_fixed(98304);
        op = rand_fixed(600 << FRAC_BITS);
        oq = rand_fixed(600 << FRAC_BITS);
      end
      5: begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 2);
      end
      default: ;
    endcase
    // junk above the size field now and then
    write_reg(IDX_IMAGE_WIDTH, ($urandom_range(0, 3) == 0) ? (($urandom & ~32'h3FF) | w) : w);
    write_reg(IDX_IMAGE_HEIGHT, ($urandom_range(0, 3) == 0) ? (($urandom & ~32'h3FF) | h) : h);
    write_reg(IDX_COEF_A, ca);
    write_reg(IDX_COEF_B, cb);
    write_reg(IDX_OFFSET_P, op);
    write_reg(IDX_COEF_C, cc);
    write_reg(IDX_COEF_D, cd);
    write_reg(IDX_OFFSET_Q, oq);
  endtask

  // random loads and requests around the image in use, warp changed every so often
  task automatic run_random_phase(input int unsigned count, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int unsigned first;
    int unsigned next_warp;
    int unsigned span;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = items_sent;
    next_warp = first;
    span = 0;
    while (items_sent - first < count) begin
      if (items_sent >= next_warp) begin
        settle_block();
        randomize_warp();
        next_warp = items_sent + $urandom_range(60, 200);
        span = 2 * ((cols_in_use > rows_in_use) ? cols_in_use : rows_in_use) + 8;
        if (span > 511)
          span = 511;
      end
      // sender waits for every pending result to come back now and then
      if ($urandom_range(0, 149) == 0)
        hold_until_drained();
      if ($urandom_range(0, 99) < 30) begin
        if ($urandom_range(0, 9) < 7)
          send_load($urandom_range(0, span), $urandom_range(0, span), PIXEL_W'($urandom));
        else
          send_load($urandom_range(0, 511), $urandom_range(0, 511), PIXEL_W'($urandom));
      end else if ($urandom_range(0, 99) < 85) begin
        send_request($urandom_range(0, span), $urandom_range(0, span));
      end else begin
        send_request($urandom_range(0, 511), $urandom_range(0, 511));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_stall_pct = 62;
    test_store_corners();
    test_load_then_read();
    test_size_registers();
    test_negative_fraction();
    test_extreme_coefficients();
    test_out_of_size_requests();

    run_random_phase(640, 18, 62);
    run_random_phase(640, 62, 18);
    run_random_phase(620, 0, 0);

    settle_block();
    if (failures == 0 && expected_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog far above the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
